/* rtl/core/sha256ms_pkg.sv */
// Shared types, constants and sigma functions for the SHA-256 message schedule block.
package sha256ms_pkg;

	localparam int unsigned WordW    = 32;
	localparam int unsigned ByteW    = 8;
	localparam int unsigned IdxW     = 6;
	localparam int unsigned WinDepth = 16;
	localparam int unsigned OutDataW = 40;

	localparam logic [IdxW-1:0] LastPos  = 6'd63;
	localparam logic [IdxW-1:0] FirstExp = 6'd16;
	localparam logic [IdxW-1:0] LastIdx  = 6'd63;

	typedef struct packed {
		logic            byte_en;
		logic            word_en;
		logic            exp_en;
		logic [IdxW-1:0] idx;
	} sms_cmd_t;

	typedef struct packed {
		logic out_free;
	} sms_stat_t;

	function automatic logic [WordW-1:0] sigma0(input logic [WordW-1:0] x);
		sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
	endfunction

	function automatic logic [WordW-1:0] sigma1(input logic [WordW-1:0] x);
		sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
	endfunction

endpackage

/* rtl/core/sha256_message_schedule_top.sv */
// Top level of the SHA-256 message schedule expansion block.
// Bytes of padded 64-byte blocks arrive one per beat on the slave stream; each
// fourth byte completes a big-endian word, sent out as W[0]..W[15] with its
// index. The beat carrying byte 63 yields W[15], after which the block runs an
// expansion burst emitting W[16]..W[63], one word per cycle while the master
// side does not stall, through a single schedule adder, with tlast on W[63];
// no bytes are taken during the burst. A single output register sits between
// the two sides, so a byte is taken while an earlier word is being handed over.
module sha256_message_schedule_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [31:0] sched_word, [37:32] word_index, [39:38] zero
	output logic        m_tlast    // block_done
);
	import sha256ms_pkg::*;

	sms_cmd_t  cmd;
	sms_stat_t stat;

	sha256ms_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	sha256ms_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.data_byte (s_tdata),
		.cmd       (cmd),
		.stat      (stat),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.exp_en && (cmd.word_en || cmd.byte_en)))
		else $error("expansion overlaps byte intake");

	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[37:32] == LastIdx)
		else $error("tlast on a word other than the last of the block");

	a_burst_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.word_en && cmd.idx == 6'd15 |=> !s_tready)
		else $error("byte intake open at start of expansion burst");

endmodule

/* rtl/core/sha256ms_ctrl.sv */
// Controller: byte position, expansion counter and phase state machine.
module sha256ms_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  sha256ms_pkg::sms_stat_t stat,
	output sha256ms_pkg::sms_cmd_t  cmd
);
	import sha256ms_pkg::*;

	typedef enum logic {
		ST_BYTES,
		ST_EXPAND
	} state_t;

	state_t          state_q;
	logic [IdxW-1:0] pos_q;
	logic [IdxW-1:0] exp_idx_q;
	logic            accept;

	assign s_tready = (state_q == ST_BYTES) && stat.out_free;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		cmd.byte_en = accept && (pos_q[1:0] != 2'b11);
		cmd.word_en = accept && (pos_q[1:0] == 2'b11);
		cmd.exp_en  = (state_q == ST_EXPAND) && stat.out_free;
		cmd.idx     = (state_q == ST_EXPAND) ? exp_idx_q : {2'b00, pos_q[5:2]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_BYTES;
			pos_q     <= '0;
			exp_idx_q <= FirstExp;
		end else begin
			case (state_q)
				ST_BYTES: begin
					if (accept) begin
						pos_q <= pos_q + 6'd1;
						// last byte of the block: start the expansion burst
						if (pos_q == LastPos) begin
							state_q   <= ST_EXPAND;
							exp_idx_q <= FirstExp;
						end
					end
				end
				ST_EXPAND: begin
					if (cmd.exp_en) begin
						exp_idx_q <= exp_idx_q + 6'd1;
						if (exp_idx_q == LastIdx) begin
							state_q <= ST_BYTES;
						end
					end
				end
				default: state_q <= ST_BYTES;
			endcase
		end
	end

endmodule

/* rtl/core/sha256ms_dp.sv */
// Datapath: byte packing, 16-word shift window, schedule adder and output register.
module sha256ms_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [sha256ms_pkg::ByteW-1:0]      data_byte,
	input  sha256ms_pkg::sms_cmd_t              cmd,
	output sha256ms_pkg::sms_stat_t             stat,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [sha256ms_pkg::OutDataW-1:0]   m_tdata,
	output logic                                m_tlast
);
	import sha256ms_pkg::*;

	logic [23:0]      partial_q;
	logic [WordW-1:0] win_q [WinDepth];
	logic [WordW-1:0] exp_word;
	logic [WordW-1:0] new_word;
	logic             push;
	logic             out_valid_q;
	logic [WordW-1:0] out_word_q;
	logic [IdxW-1:0]  out_idx_q;
	logic             out_last_q;

	// window tap k holds W[i-1-k] for the word i being formed
	assign exp_word = sigma1(win_q[1]) + win_q[6] + sigma0(win_q[14]) + win_q[15];
	assign new_word = cmd.word_en ? {partial_q, data_byte} : exp_word;
	assign push     = cmd.word_en || cmd.exp_en;

	assign stat.out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk) begin
		if (cmd.byte_en) begin
			partial_q <= {partial_q[15:0], data_byte};
		end
		if (push) begin
			win_q[0] <= new_word;
			for (int k = 1; k < WinDepth; k++) begin
				win_q[k] <= win_q[k-1];
			end
			out_word_q <= new_word;
			out_idx_q  <= cmd.idx;
			out_last_q <= (cmd.idx == LastIdx);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_idx_q, out_word_q};
	assign m_tlast  = out_last_q;

endmodule
